// ----- rtl/core/wheel_slip_tire_force_assert.svh -----
// Assertion macros for the tire force block.
// Each one expects clk and rst in scope.
`ifndef WHEEL_SLIP_TIRE_FORCE_ASSERT_SVH
`define WHEEL_SLIP_TIRE_FORCE_ASSERT_SVH

// Same-cycle implication
`define WST_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wst: same-cycle check failed");

// Next-cycle implication
`define WST_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wst: next-cycle check failed");

`endif

// ----- rtl/core/wst_pkg.sv -----
`timescale 1ns / 1ps

package wst_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int VW           = 46;   // CORDIC x/y width
  localparam int ZW           = 20;   // CORDIC angle width, Q.16 radians
  localparam int DIV_BITS     = 16;   // quotient bits after the overflow check

  // Angles in Q.16 radians
  localparam logic signed [23:0] ANG_PI      = 24'sd205887;
  localparam logic signed [23:0] ANG_TWO_PI  = 24'sd411775;
  localparam logic signed [23:0] ANG_FOUR_PI = 24'sd823550;
  localparam logic signed [23:0] ANG_HALF_PI = 24'sd102944;

  // CORDIC start vectors
  localparam logic signed [VW-1:0] ATAN_X0 = 46'sd1048576;  // 1.0 in Q.20
  localparam logic signed [VW-1:0] SIN_X0  = 46'sd636751;   // 1/gain in Q.20

  // Register indexes
  localparam logic [2:0] CFG_RADIUS = 3'd0;
  localparam logic [2:0] CFG_PEAK   = 3'd1;
  localparam logic [2:0] CFG_STIFF  = 3'd2;
  localparam logic [2:0] CFG_SHAPE  = 3'd3;
  localparam logic [2:0] CFG_CURVE  = 3'd4;

  // Reset values
  localparam logic [15:0]        RADIUS_RST = 16'd2097;
  localparam logic [15:0]        PEAK_RST   = 16'd1884;
  localparam logic [15:0]        STIFF_RST  = 16'd2560;
  localparam logic [14:0]        SHAPE_RST  = 15'd9421;
  localparam logic signed [15:0] CURVE_RST  = 16'sd2744;

  typedef struct packed {
    logic [1:0]         wheel_index;
    logic signed [15:0] wheel_rate;
    logic signed [15:0] vehicle_speed;
    logic signed [15:0] accel_x;
  } wst_in_t;

  typedef struct packed {
    logic [1:0]         wheel_out;
    logic signed [15:0] slip_ratio;
    logic signed [15:0] tire_force;
    logic               slip_clipped;
  } wst_out_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
  } wst_vec_t;

  // Item data carried alongside a CORDIC pipe
  typedef struct packed {
    logic [1:0]         wheel;
    logic signed [15:0] slip;
    logic               clip;
    logic signed [34:0] bx;
  } wst_side_t;

  // atan(2^-i) in Q.16
  function automatic logic signed [ZW-1:0] atan_entry(input int unsigned idx);
    logic signed [ZW-1:0] r;
    case (idx)
      0:       r = 20'sd51472;
      1:       r = 20'sd30386;
      2:       r = 20'sd16055;
      3:       r = 20'sd8150;
      4:       r = 20'sd4091;
      5:       r = 20'sd2047;
      6:       r = 20'sd1024;
      7:       r = 20'sd512;
      8:       r = 20'sd256;
      9:       r = 20'sd128;
      10:      r = 20'sd64;
      11:      r = 20'sd32;
      12:      r = 20'sd16;
      13:      r = 20'sd8;
      14:      r = 20'sd4;
      15:      r = 20'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/wheel_slip_tire_force.sv -----
`timescale 1ns / 1ps

// Channel   Signals                                  Direction
// in        in_valid, in_ready, in_data (wst_in_t)   item in
// out       out_valid, out_ready, out_data           result out
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data register write
//
// One item per cycle while the output is not stalled; 12 arithmetic stages,
// a 16-stage restoring divider and three 16-stage CORDIC pipes.
// The whole pipeline advances together whenever the output register is empty
// or being taken; otherwise every stage holds.
// Synchronous reset clears valid bits and loads the register defaults.
module wheel_slip_tire_force (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  wst_pkg::wst_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output wst_pkg::wst_out_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_data
);
  import wst_pkg::*;

  typedef struct packed {
    logic [1:0]  wheel;
    logic        neg;
    logic        ovf;
    logic        zero;
    logic [15:0] den;
    logic [31:0] rem;
    logic [15:0] q;
  } div_t;

  logic en;

  // configuration registers
  logic [15:0]        radius;
  logic [15:0]        peak;
  logic [15:0]        stiff;
  logic [14:0]        shape;
  logic signed [15:0] curve;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RST;
      peak   <= PEAK_RST;
      stiff  <= STIFF_RST;
      shape  <= SHAPE_RST;
      curve  <= CURVE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RADIUS: radius <= cfg_data;
        CFG_PEAK:   peak   <= cfg_data;
        CFG_STIFF:  stiff  <= cfg_data;
        CFG_SHAPE:  shape  <= cfg_data[14:0];
        CFG_CURVE:  curve  <= cfg_data;
        default: ;
      endcase
    end
  end

  // global stall: move when the output slot is free
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1: wheel speed product
  logic               s1_valid;
  logic [1:0]         s1_wheel;
  logic signed [15:0] s1_vspd;
  logic               s1_ax_pos, s1_ax_neg;
  logic signed [32:0] s1_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_wheel  <= in_data.wheel_index;
      s1_vspd   <= in_data.vehicle_speed;
      s1_ax_pos <= !in_data.accel_x[15] && (in_data.accel_x != '0);
      s1_ax_neg <= in_data.accel_x[15];
      s1_prod   <= in_data.wheel_rate * $signed({1'b0, radius});
    end
  end

  // stage 2: slip numerator and divisor as magnitudes
  logic signed [16:0] lin, divisor;
  logic signed [17:0] diff;
  logic [16:0]        diff_mag, div_mag;
  logic               s2_valid;
  logic [1:0]         s2_wheel;
  logic               s2_neg, s2_zero;
  logic [27:0]        s2_num;
  logic [15:0]        s2_den;

  always_comb begin
    lin      = s1_prod[32:16];
    diff     = {lin[16], lin} - {{2{s1_vspd[15]}}, s1_vspd};
    divisor  = s1_ax_pos ? lin : {s1_vspd[15], s1_vspd};
    diff_mag = diff[17] ? 17'(-diff) : diff[16:0];
    div_mag  = divisor[16] ? 17'(-divisor) : 17'(divisor);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_wheel <= s1_wheel;
      s2_neg   <= diff[17] ^ divisor[16];
      s2_zero  <= !(s1_ax_pos || s1_ax_neg) || (divisor == '0);
      s2_num   <= {diff_mag[15:0], 12'b0};
      s2_den   <= div_mag[15:0];
    end
  end

  // stage 3: quotient overflow check, divider entry
  logic s3_valid;
  div_t s3;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3.wheel <= s2_wheel;
      s3.neg   <= s2_neg;
      s3.zero  <= s2_zero;
      s3.ovf   <= {4'b0, s2_num} >= {s2_den, 16'b0};
      s3.den   <= s2_den;
      s3.rem   <= {4'b0, s2_num};
      s3.q     <= '0;
    end
  end

  // restoring divider, one quotient bit per stage, MSB first
  logic dv [DIV_BITS];
  div_t dq [DIV_BITS];

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    localparam int B = DIV_BITS - 1 - k;
    logic        cur_v;
    div_t        cur, nxt;
    logic [32:0] trial;

    if (k == 0) begin : g_src
      assign cur_v = s3_valid;
      assign cur   = s3;
    end else begin : g_src
      assign cur_v = dv[k-1];
      assign cur   = dq[k-1];
    end

    always_comb begin
      nxt   = cur;
      trial = {1'b0, cur.rem} - {1'b0, 32'(cur.den) << B};
      if (!trial[32]) begin
        nxt.rem  = trial[31:0];
        nxt.q[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k] <= 1'b0;
      end else if (en) begin
        dv[k] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dq[k] <= nxt;
      end
    end
  end

  // stage 4: signed slip with saturation
  div_t               dl;
  logic signed [16:0] q_ext, qs;
  logic signed [15:0] slip_next;
  logic               clip_next;
  logic               s4_valid;
  logic [1:0]         s4_wheel;
  logic signed [15:0] s4_slip;
  logic               s4_clip;

  always_comb begin
    dl        = dq[DIV_BITS-1];
    q_ext     = {1'b0, dl.q};
    qs        = dl.neg ? 17'(-q_ext) : q_ext;
    slip_next = qs[15:0];
    clip_next = 1'b0;
    if (dl.zero) begin
      slip_next = '0;
    end else if (dl.ovf || qs > 17'sd32767 || qs < -17'sd32768) begin
      clip_next = 1'b1;
      slip_next = dl.neg ? 16'sh8000 : 16'sh7fff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= dv[DIV_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_wheel <= dl.wheel;
      s4_slip  <= slip_next;
      s4_clip  <= clip_next;
    end
  end

  // stage 5: bx = B * slip, first atan entry
  logic signed [32:0] prod_b;
  logic signed [28:0] bx;
  logic               s5_valid;
  wst_vec_t           s5_vec;
  wst_side_t          s5_side;

  always_comb begin
    prod_b = $signed({1'b0, stiff}) * s4_slip;
    bx     = prod_b[32:4];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_vec.x      <= ATAN_X0;
      s5_vec.y      <= {{13{bx[28]}}, bx, 4'b0};
      s5_vec.z      <= '0;
      s5_side.wheel <= s4_wheel;
      s5_side.slip  <= s4_slip;
      s5_side.clip  <= s4_clip;
      s5_side.bx    <= {{6{bx[28]}}, bx};
    end
  end

  logic      c1_valid;
  wst_vec_t  c1_vec;
  wst_side_t c1_side;

  wst_cordic u_atan_bx (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vectoring(1'b1),
    .in_valid (s5_valid),
    .in_vec   (s5_vec),
    .in_side  (s5_side),
    .out_valid(c1_valid),
    .out_vec  (c1_vec),
    .out_side (c1_side)
  );

  // stage 6: E * (bx - atan(bx))
  logic signed [29:0] bd;
  logic signed [45:0] s6_m;
  logic               s6_valid;
  wst_side_t          s6_side;

  assign bd = c1_side.bx[29:0] - {{10{c1_vec.z[ZW-1]}}, c1_vec.z};

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (en) begin
      s6_valid <= c1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_m    <= curve * bd;
      s6_side <= c1_side;
    end
  end

  // stage 7: inner argument, second atan entry
  logic signed [34:0] inner;
  logic               s7_valid;
  wst_vec_t           s7_vec;
  wst_side_t          s7_side;

  assign inner = s6_side.bx - {s6_m[45], s6_m[45:12]};

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else if (en) begin
      s7_valid <= s6_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_vec.x <= ATAN_X0;
      s7_vec.y <= {{7{inner[34]}}, inner, 4'b0};
      s7_vec.z <= '0;
      s7_side  <= s6_side;
    end
  end

  logic      c2_valid;
  wst_vec_t  c2_vec;
  wst_side_t c2_side;

  wst_cordic u_atan_inner (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vectoring(1'b1),
    .in_valid (s7_valid),
    .in_vec   (s7_vec),
    .in_side  (s7_side),
    .out_valid(c2_valid),
    .out_vec  (c2_vec),
    .out_side (c2_side)
  );

  // stage 8: phase = C * atan
  logic signed [35:0] s8_ph;
  logic               s8_valid;
  wst_side_t          s8_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_valid <= 1'b0;
    end else if (en) begin
      s8_valid <= c2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_ph   <= $signed({1'b0, shape}) * c2_vec.z;
      s8_side <= c2_side;
    end
  end

  // stage 9: remainder by 2*pi, sign follows the phase
  logic signed [23:0] ph, ph_red;
  logic signed [23:0] s9_p;
  logic               s9_valid;
  wst_side_t          s9_side;

  always_comb begin
    ph = s8_ph[35:12];
    if (ph >= ANG_FOUR_PI) begin
      ph_red = ph - ANG_FOUR_PI;
    end else if (ph >= ANG_TWO_PI) begin
      ph_red = ph - ANG_TWO_PI;
    end else if (ph <= -ANG_FOUR_PI) begin
      ph_red = ph + ANG_FOUR_PI;
    end else if (ph <= -ANG_TWO_PI) begin
      ph_red = ph + ANG_TWO_PI;
    end else begin
      ph_red = ph;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_valid <= 1'b0;
    end else if (en) begin
      s9_valid <= s8_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s9_p    <= ph_red;
      s9_side <= s8_side;
    end
  end

  // stage 10: wrap into +-pi, fold into +-pi/2, sin entry
  logic signed [23:0] pw, pf;
  logic               s10_valid;
  wst_vec_t           s10_vec;
  wst_side_t          s10_side;

  always_comb begin
    if (s9_p > ANG_PI) begin
      pw = s9_p - ANG_TWO_PI;
    end else if (s9_p < -ANG_PI) begin
      pw = s9_p + ANG_TWO_PI;
    end else begin
      pw = s9_p;
    end
    if (pw > ANG_HALF_PI) begin
      pf = ANG_PI - pw;
    end else if (pw < -ANG_HALF_PI) begin
      pf = -ANG_PI - pw;
    end else begin
      pf = pw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_valid <= 1'b0;
    end else if (en) begin
      s10_valid <= s9_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s10_vec.x <= SIN_X0;
      s10_vec.y <= '0;
      s10_vec.z <= pf[ZW-1:0];
      s10_side  <= s9_side;
    end
  end

  logic      c3_valid;
  wst_vec_t  c3_vec;
  wst_side_t c3_side;

  wst_cordic u_sin (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vectoring(1'b0),
    .in_valid (s10_valid),
    .in_vec   (s10_vec),
    .in_side  (s10_side),
    .out_valid(c3_valid),
    .out_vec  (c3_vec),
    .out_side (c3_side)
  );

  // stage 11: D * sin
  logic signed [40:0] s11_f;
  logic               s11_valid;
  wst_side_t          s11_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s11_valid <= 1'b0;
    end else if (en) begin
      s11_valid <= c3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s11_f    <= $signed({1'b0, peak}) * $signed(c3_vec.y[23:0]);
      s11_side <= c3_side;
    end
  end

  // stage 12: force saturation into the output register
  logic signed [20:0] fw;
  logic signed [15:0] force_sat;

  always_comb begin
    fw = s11_f[40:20];
    if (fw > 21'sd32767) begin
      force_sat = 16'sh7fff;
    end else if (fw < -21'sd32768) begin
      force_sat = 16'sh8000;
    end else begin
      force_sat = fw[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s11_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.wheel_out    <= s11_side.wheel;
      out_data.slip_ratio   <= s11_side.slip;
      out_data.tire_force   <= force_sat;
      out_data.slip_clipped <= s11_side.clip;
    end
  end

  `include "wheel_slip_tire_force_assert.svh"

  // a clipped slip sits at one of the rails
  `WST_ASSERT_IMPL(a_clip_rail, out_valid && out_data.slip_clipped, out_data.slip_ratio == 16'sh7fff || out_data.slip_ratio == 16'sh8000)
  // a stall freezes the sine unit output and the stage behind it
  `WST_ASSERT_NEXT(a_stall_hold, !in_ready, $stable(c3_valid) && $stable(s11_valid))
  // a stall with a result waiting keeps the divider output valid and the stage 4 slip steady
  `WST_ASSERT_NEXT(a_div_hold, out_valid && !out_ready, $stable(dv[DIV_BITS-1]) && $stable(s4_slip))

endmodule

// ----- rtl/core/wst_cordic.sv -----
`timescale 1ns / 1ps

// Pipelined CORDIC, one micro-rotation per stage.
// vectoring high: drive y to zero (atan in z); low: drive z to zero (sin in y).
module wst_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               vectoring,
  input  logic               in_valid,
  input  wst_pkg::wst_vec_t  in_vec,
  input  wst_pkg::wst_side_t in_side,
  output logic               out_valid,
  output wst_pkg::wst_vec_t  out_vec,
  output wst_pkg::wst_side_t out_side
);
  import wst_pkg::*;

  logic      valid_q [CORDIC_STEPS];
  wst_vec_t  vec_q   [CORDIC_STEPS];
  wst_side_t side_q  [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic                 cur_valid;
    wst_vec_t             cur_vec;
    wst_side_t            cur_side;
    wst_vec_t             nxt;
    logic signed [VW-1:0] x, y, xs, ys;
    logic signed [ZW-1:0] z;
    logic                 up;

    if (i == 0) begin : g_src
      assign cur_valid = in_valid;
      assign cur_vec   = in_vec;
      assign cur_side  = in_side;
    end else begin : g_src
      assign cur_valid = valid_q[i-1];
      assign cur_vec   = vec_q[i-1];
      assign cur_side  = side_q[i-1];
    end

    // one micro-rotation
    always_comb begin
      x  = cur_vec.x;
      y  = cur_vec.y;
      z  = cur_vec.z;
      xs = x >>> i;
      ys = y >>> i;
      up = vectoring ? (y <= 0) : (z >= 0);
      if (up) begin
        nxt.x = x - ys;
        nxt.y = y + xs;
        nxt.z = z - atan_entry(i);
      end else begin
        nxt.x = x + ys;
        nxt.y = y - xs;
        nxt.z = z + atan_entry(i);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[i] <= 1'b0;
      end else if (en) begin
        valid_q[i] <= cur_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        vec_q[i]  <= nxt;
        side_q[i] <= cur_side;
      end
    end
  end

  assign out_valid = valid_q[CORDIC_STEPS-1];
  assign out_vec   = vec_q[CORDIC_STEPS-1];
  assign out_side  = side_q[CORDIC_STEPS-1];

endmodule
